>>> rtl/simon_64_128_block_cipher_unit_assert.svh
// Assertion macros for the SIMON 64/128 cipher unit.
`ifndef SIMON_64_128_BLOCK_CIPHER_UNIT_ASSERT_SVH
`define SIMON_64_128_BLOCK_CIPHER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define SIMON_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SIMON_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SIMON_ASSERT_IMP(lbl, ante, cons, msg)
`define SIMON_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/simon_pkg.sv
`default_nettype none
package simon_pkg;

	localparam int ROUNDS = 44;
	localparam int KEY_WORDS = 4;
	localparam logic [63:0] Z_SEQ = 64'hfc2ce51207a635db;

	typedef struct packed {
		logic load_enc;
		logic load_dec;
		logic step;
	} ks_ctl_t;

	typedef struct packed {
		logic        busy;
		logic [31:0] rkey;
	} ks_sts_t;

	function automatic logic [31:0] round_f(input logic [31:0] v);
		logic [31:0] r1;
		logic [31:0] r2;
		logic [31:0] r8;
		r1 = {v[30:0], v[31]};
		r2 = {v[29:0], v[31:30]};
		r8 = {v[23:0], v[31:24]};
		return (r1 & r8) ^ r2;
	endfunction

	// k_new = ~k_far ^ t ^ (t >>> 1) ^ z ^ 3, t = (k_near >>> 3) ^ k_mid
	function automatic logic [31:0] sched_f(input logic [31:0] k_far,
			input logic [31:0] k_near, input logic [31:0] k_mid, input logic zb);
		logic [31:0] t;
		t = {k_near[2:0], k_near[31:3]} ^ k_mid;
		t = t ^ {t[0], t[31:1]};
		return ~k_far ^ t ^ {31'd0, zb} ^ 32'd3;
	endfunction

endpackage
`default_nettype wire

>>> rtl/simon_ks.sv
`default_nettype none
module simon_ks (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [1:0]            wr_index,
	input  wire logic [31:0]           wr_data,
	input  wire simon_pkg::ks_ctl_t    ctl,
	output simon_pkg::ks_sts_t         sts
);

	typedef enum logic [2:0] {
		KS_LOAD  = 3'b001,
		KS_EXP   = 3'b010,
		KS_READY = 3'b100
	} ks_state_t;

	ks_state_t   state_q;
	logic [31:0] key_q  [simon_pkg::KEY_WORDS];
	logic [31:0] win_q  [simon_pkg::KEY_WORDS];
	logic [31:0] tail_q [simon_pkg::KEY_WORDS];
	logic [5:0]  idx_q;
	logic        dir_q;
	logic        bwd;
	logic        zb;
	logic        exp_last;
	logic [31:0] nk;

	assign bwd      = dir_q && (state_q == KS_READY);
	assign zb       = simon_pkg::Z_SEQ[idx_q];
	assign exp_last = idx_q == 6'(simon_pkg::ROUNDS - 5);
	assign nk = bwd ? simon_pkg::sched_f(win_q[3], win_q[2], win_q[0], zb)
	                : simon_pkg::sched_f(win_q[0], win_q[3], win_q[1], zb);

	assign sts.busy = state_q != KS_READY;
	assign sts.rkey = dir_q ? win_q[3] : win_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= KS_LOAD;
			idx_q   <= '0;
			dir_q   <= 1'b0;
			for (int i = 0; i < simon_pkg::KEY_WORDS; i++) begin
				key_q[i] <= '0;
			end
		end else if (wr_en) begin
			key_q[wr_index] <= wr_data;
			state_q         <= KS_LOAD;
		end else begin
			case (state_q)
				KS_LOAD: begin
					idx_q   <= '0;
					dir_q   <= 1'b0;
					state_q <= KS_EXP;
				end
				KS_EXP: begin
					idx_q <= idx_q + 6'd1;
					if (exp_last) begin
						state_q <= KS_READY;
					end
				end
				KS_READY: begin
					if (ctl.load_enc) begin
						idx_q <= '0;
						dir_q <= 1'b0;
					end else if (ctl.load_dec) begin
						idx_q <= 6'(simon_pkg::ROUNDS - 5);
						dir_q <= 1'b1;
					end else if (ctl.step) begin
						idx_q <= dir_q ? idx_q - 6'd1 : idx_q + 6'd1;
					end
				end
				default: state_q <= KS_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			KS_LOAD: begin
				win_q <= key_q;
			end
			KS_EXP: begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= win_q[3];
				win_q[3] <= nk;
				if (exp_last) begin
					tail_q[0] <= win_q[1];
					tail_q[1] <= win_q[2];
					tail_q[2] <= win_q[3];
					tail_q[3] <= nk;
				end
			end
			KS_READY: begin
				if (ctl.load_enc) begin
					win_q <= key_q;
				end else if (ctl.load_dec) begin
					win_q <= tail_q;
				end else if (ctl.step && bwd) begin
					win_q[3] <= win_q[2];
					win_q[2] <= win_q[1];
					win_q[1] <= win_q[0];
					win_q[0] <= nk;
				end else if (ctl.step) begin
					win_q[0] <= win_q[1];
					win_q[1] <= win_q[2];
					win_q[2] <= win_q[3];
					win_q[3] <= nk;
				end
			end
			default: win_q <= key_q;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/simon_64_128_block_cipher_unit.sv
// Channel  Dir  tdata                   tuser
// s_*      in   block_in[63:0]          kind (0 encrypt, 1 decrypt)
// m_*      out  block_out[63:0]         -
// wr_*     in   key word wr_data[31:0] at index wr_index[1:0]
//
// A block is loaded on acceptance, then takes 44 rounds, one per cycle, on
// the shared round unit while the key window steps forward or backward.
// After reset and after each key write the schedule runs; no transaction
// is taken meanwhile. A stalled result holds the last round.
`default_nettype none
`include "simon_64_128_block_cipher_unit_assert.svh"
module simon_64_128_block_cipher_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // block_in
	input  wire logic        s_tuser,   // kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [63:0] m_tdata,   // block_out
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [31:0] wr_data
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t               state_q;
	logic [5:0]           rnd_q;
	logic                 dec_q;
	logic [31:0]          x_q;
	logic [31:0]          y_q;
	logic                 m_valid_q;
	logic [63:0]          m_data_q;
	logic                 accept;
	logic                 last;
	logic                 finish;
	logic [31:0]          a;
	logic [31:0]          nw;
	logic [63:0]          res;
	simon_pkg::ks_ctl_t   ks_ctl;
	simon_pkg::ks_sts_t   ks_sts;

	simon_ks u_ks (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.ctl      (ks_ctl),
		.sts      (ks_sts)
	);

	assign s_tready = (state_q == ST_IDLE) && !ks_sts.busy && !wr_en;
	assign accept   = s_tvalid && s_tready;
	assign last     = rnd_q == 6'(simon_pkg::ROUNDS - 1);
	assign finish   = (state_q == ST_RUN) && last && (!m_valid_q || m_tready);

	assign a   = dec_q ? y_q : x_q;
	assign nw  = (dec_q ? x_q : y_q) ^ simon_pkg::round_f(a) ^ ks_sts.rkey;
	assign res = dec_q ? {a, nw} : {nw, a};

	assign ks_ctl.load_enc = accept && !s_tuser;
	assign ks_ctl.load_dec = accept && s_tuser;
	assign ks_ctl.step     = (state_q == ST_RUN) && !last;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rnd_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rnd_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (!last) begin
						rnd_q <= rnd_q + 6'd1;
					end else if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= s_tdata[63:32];
			y_q   <= s_tdata[31:0];
			dec_q <= s_tuser;
		end else if (ks_ctl.step) begin
			x_q <= res[63:32];
			y_q <= res[31:0];
		end
		if (finish) begin
			m_data_q <= res;
		end
	end

	`SIMON_ASSERT_IMP(a_busy_blocks, ks_sts.busy, !s_tready, "input taken during key schedule")
	`SIMON_ASSERT_NXT(a_accept_runs, accept, state_q == ST_RUN && rnd_q == 6'd0, "round count not cleared")
	`SIMON_ASSERT_IMP(a_out_after_last, $rose(m_tvalid), $past(state_q == ST_RUN && last), "result before last round")

endmodule
`default_nettype wire
